/* hw/rtl/hsv_to_rgb_converter_macros.svh */
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Shared concurrent assertion wrappers, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// Property that must hold at every edge outside reset.
`define H2R_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication: antecedent at this edge implies consequent as written.
`define H2R_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/hsv2rgb_pkg.sv */
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Field widths, sector codes and the exact divide-by-255 helper.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int unsigned HueW  = 16;
  localparam int unsigned ChanW = 8;
  localparam int unsigned WW    = HueW + 1;        // blend weight, 0..65536
  localparam int unsigned ProdW = 2 * ChanW + WW;  // B*S*w
  localparam int unsigned PipeDepth = 4;

  // Six hue sectors, named by the primary/secondary pair they span.
  typedef enum logic [2:0] {
    SEC_R_Y = 3'd0,
    SEC_Y_G = 3'd1,
    SEC_G_C = 3'd2,
    SEC_C_B = 3'd3,
    SEC_B_M = 3'd4,
    SEC_M_R = 3'd5
  } sector_t;

  // floor(x/255), exact for x <= 255*255.
  function automatic logic [ChanW-1:0] div255(input logic [2*ChanW-1:0] x);
    logic [2*ChanW:0] s;
    s = {1'b0, x} + 17'd1 + {9'd0, x[2*ChanW-1:ChanW]};
    return s[2*ChanW-1:ChanW];
  endfunction

endpackage

/* hw/rtl/hsv_to_rgb_converter.sv */
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Six-sector hue/saturation/value to 8-bit RGB, exact fixed point, pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_hue, in_saturation, in_brightness and raise start
//   for one cycle per request. busy is tied low, so a request is taken at
//   every edge where start is high: one request per clock, back to back.
//   Result channel: out_valid pulses for one cycle with out_red, out_green,
//   out_blue. The receiver cannot stall; it must sample on that cycle.
//   Throughput: 1 request per cycle. A request passes through the four
//   register stages below (sector/weight and 8x8 products, the 16x17 blend
//   multiply, the offset add, divide-by-255 and channel routing).
//   Reset (rst_n low, synchronous) clears the stage valid bits; requests in
//   flight are dropped and no result appears until a new request arrives.
//   Math: with c = B*S, m = B*(255-S) and weight w in [0, 65536]:
//     max channel = B, min channel = floor(m/255),
//     mid channel = floor((m + (B*S*w >> 16)) / 255).
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_macros.svh"

module hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [HueW-1:0]  in_hue,
  input  logic [ChanW-1:0] in_saturation,
  input  logic [ChanW-1:0] in_brightness,
  output logic             out_valid,
  output logic [ChanW-1:0] out_red,
  output logic [ChanW-1:0] out_green,
  output logic [ChanW-1:0] out_blue
);

  // Pipeline never stalls, so it always takes a new request.
  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // Stage 1: sector, blend weight, chroma and offset products
  // --------------------------------------------------------------------------
  logic [HueW+2:0]    six;
  logic [WW-1:0]      t_frac;
  logic [WW-1:0]      w_nxt;
  logic [ChanW-1:0]   sat_inv;
  logic [2*ChanW-1:0] bs_nxt;
  logic [2*ChanW-1:0] bns_nxt;

  always_comb begin
    six    = 19'(in_hue) * 19'd6;
    t_frac = six[WW-1:0];
    // triangle wave: rising in even sectors, falling in odd ones
    if (t_frac[WW-1]) begin
      w_nxt = 17'(18'h20000 - 18'(t_frac));
    end else begin
      w_nxt = t_frac;
    end
    sat_inv = ~in_saturation;  // 255 - S
    bs_nxt  = (2*ChanW)'(in_brightness) * (2*ChanW)'(in_saturation);
    bns_nxt = (2*ChanW)'(in_brightness) * (2*ChanW)'(sat_inv);
  end

  logic               v1_r;
  sector_t            sec1_r;
  logic [WW-1:0]      w1_r;
  logic [2*ChanW-1:0] bs1_r;
  logic [2*ChanW-1:0] bns1_r;
  logic [ChanW-1:0]   bri1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    sec1_r <= sector_t'(six[HueW+2:HueW]);
    w1_r   <= w_nxt;
    bs1_r  <= bs_nxt;
    bns1_r <= bns_nxt;
    bri1_r <= in_brightness;
  end

  // --------------------------------------------------------------------------
  // Stage 2: blend multiply B*S*w
  // --------------------------------------------------------------------------
  logic               v2_r;
  sector_t            sec2_r;
  logic [ProdW-1:0]   prod2_r;
  logic [2*ChanW-1:0] bns2_r;
  logic [ChanW-1:0]   bri2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    sec2_r  <= sec1_r;
    prod2_r <= ProdW'(bs1_r) * ProdW'(w1_r);
    bns2_r  <= bns1_r;
    bri2_r  <= bri1_r;
  end

  // --------------------------------------------------------------------------
  // Stage 3: mid-channel numerator; low 16 bits of m*65536 are zero
  // --------------------------------------------------------------------------
  logic [2*ChanW:0]   xq_sum;
  logic               v3_r;
  sector_t            sec3_r;
  logic [2*ChanW-1:0] xq3_r;
  logic [2*ChanW-1:0] zq3_r;
  logic [ChanW-1:0]   bri3_r;

  assign xq_sum = {1'b0, bns2_r} + prod2_r[ProdW-1:HueW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    sec3_r <= sec2_r;
    xq3_r  <= xq_sum[2*ChanW-1:0];  // bounded by 255*255
    zq3_r  <= bns2_r;
    bri3_r <= bri2_r;
  end

  // --------------------------------------------------------------------------
  // Stage 4: divide by 255, route max/mid/min onto channels
  // --------------------------------------------------------------------------
  logic [ChanW-1:0] x8;
  logic [ChanW-1:0] z8;
  logic [ChanW-1:0] red_nxt;
  logic [ChanW-1:0] green_nxt;
  logic [ChanW-1:0] blue_nxt;

  always_comb begin
    x8 = div255(xq3_r);
    z8 = div255(zq3_r);
    unique case (sec3_r)
      SEC_R_Y: begin red_nxt = bri3_r; green_nxt = x8;     blue_nxt = z8;     end
      SEC_Y_G: begin red_nxt = x8;     green_nxt = bri3_r; blue_nxt = z8;     end
      SEC_G_C: begin red_nxt = z8;     green_nxt = bri3_r; blue_nxt = x8;     end
      SEC_C_B: begin red_nxt = z8;     green_nxt = x8;     blue_nxt = bri3_r; end
      SEC_B_M: begin red_nxt = x8;     green_nxt = z8;     blue_nxt = bri3_r; end
      default: begin red_nxt = bri3_r; green_nxt = z8;     blue_nxt = x8;     end
    endcase
  end

  logic             out_valid_r;
  logic [ChanW-1:0] red_r;
  logic [ChanW-1:0] green_r;
  logic [ChanW-1:0] blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // largest channel of the result now on the ports
  logic [ChanW-1:0] rg_max;
  logic [ChanW-1:0] max_ch;

  assign rg_max = (out_red > out_green) ? out_red : out_green;
  assign max_ch = (rg_max > out_blue) ? rg_max : out_blue;

  `H2R_ASSERT_IMPL(a_latency, start, ##PipeDepth out_valid, "request produced no result")
  `H2R_ASSERT_IMPL(a_no_stray, out_valid, $past(start, PipeDepth), "result without request")
  `H2R_ASSERT_IMPL(a_max, out_valid, max_ch == $past(in_brightness, PipeDepth), "max != value")
  `H2R_ASSERT_ALWAYS(a_valid_known, !$isunknown(out_valid), "out_valid unknown")

endmodule
